>>> rtl/swlm_pkg.sv
// Shared types and constants for the sliding window level meter.
// No dependencies; swlm_div, swlm_back and the top level import this package.
package swlm_pkg;

	localparam int MAX_BLOCKS_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int LOG_FRAC_BITS   = 16;

	localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;

	localparam logic [15:0]        SUB_BLOCK_RST = 16'd2400;
	localparam logic [6:0]         WINDOW_RST    = 7'd60;
	localparam logic signed [15:0] CAL_RST       = 16'sd0;
	localparam logic signed [15:0] FLOOR_RST     = -16'sd30720;

	typedef enum logic [7:0] {
		CFG_SUB_BLOCK = 8'd0,
		CFG_WINDOW    = 8'd1,
		CFG_CAL       = 8'd2,
		CFG_FLOOR     = 8'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIV1,
		ST_CLOSE,
		ST_DIV2,
		ST_NORM,
		ST_LOG,
		ST_MUL,
		ST_FIN
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/swlm_fifo.sv
// Two entry queue between the front part and the back part of the meter.
// Depends on nothing but the clock and reset.
module swlm_fifo #(
	parameter int W = 47
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] ent_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

endmodule

>>> rtl/swlm_front.sv
// Front part: takes samples in, forms the magnitude and its square.
// Feeds swlm_fifo; uses no package items.
module swlm_front #(
	parameter int SB = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SB-1:0]     sample_in,
	input  logic              full,
	output logic              push,
	output logic [2*SB-2:0]   push_data
);
	logic [SB-1:0]   smp_s1;
	logic            vld_s1;
	logic [SB-1:0]   mag;
	logic [2*SB-1:0] sq;

	assign push     = vld_s1 && !full;
	assign in_ready = !vld_s1 || !full;

	always_comb begin
		mag       = smp_s1[SB-1] ? (SB'(~smp_s1) + SB'(1)) : smp_s1;
		sq        = (2*SB)'(mag) * (2*SB)'(mag);
		push_data = sq[2*SB-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			smp_s1 <= sample_in;
		end
	end

endmodule

>>> rtl/swlm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses div_status_t from swlm_pkg.
module swlm_div #(
	parameter int DW = 63,
	parameter int VW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DW-1:0]         dividend,
	input  logic [VW-1:0]         divisor,
	output swlm_pkg::div_status_t status,
	output logic [DW-1:0]         quotient
);
	import swlm_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic          ge;
	logic [VW:0]   rem_nx;

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

	always_comb begin
		rem_sh = {rem_q[VW-1:0], num_q[DW-1]};
		ge     = (rem_sh >= {1'b0, dvs_q});
		rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

>>> rtl/swlm_back.sv
// Back part: sub-block sums, block ring, window sum, log2 and dB level.
// Uses swlm_pkg and instantiates swlm_div.
module swlm_back #(
	parameter int SB   = 24,
	parameter int MAXB = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic [15:0]         sub_block_samples,
	input  logic [6:0]          window_blocks,
	input  logic signed [15:0]  calibration_offset,
	input  logic signed [15:0]  silence_floor,
	input  logic                empty,
	input  logic [2*SB-2:0]     rdata,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  level_db,
	output logic                window_primed,
	output logic [6:0]          blocks_filled
);
	import swlm_pkg::*;

	localparam int SQW = 2 * SB - 1;
	localparam int PSW = SQW + 16;
	localparam int NW  = $clog2(MAXB + 1);
	localparam int PW  = (MAXB > 1) ? $clog2(MAXB) : 1;
	localparam int WEW = SQW + NW;
	localparam int DW  = (PSW > WEW + 1) ? PSW : WEW + 1;
	localparam int SW  = $clog2(DW);
	localparam int LW  = SW + 18;
	localparam int PRW = LW + 19;

	back_state_t state_q, state_d;

	logic [PSW-1:0] psum_q;
	logic [15:0]    pcnt_q;
	logic [SQW-1:0] ring_mem [MAXB];
	logic [MAXB-1:0] vld_q;
	logic [SQW-1:0] rd_q;
	logic           rdv_q;
	logic [WEW-1:0] win_q;
	logic [PW-1:0]  ptr_q;
	logic [NW-1:0]  fill_q;
	logic           primed_q;
	logic           close_q;
	logic [SQW-1:0] q_q;
	logic [DW-1:0]  m_q;
	logic           zero_q;
	logic [SW-1:0]  sc_q;
	logic [30:0]    x_q;
	logic [15:0]    frac_q;
	logic [3:0]     it_q;
	logic signed [PRW-1:0] prod_q;
	logic           out_valid_q;
	logic signed [15:0] level_q;
	logic           primed_o_q;
	logic [6:0]     filled_o_q;

	logic [15:0]    blen;
	logic [NW-1:0]  ring_n;
	logic [SQW-1:0] old_e;
	logic [WEW-1:0] win_new;
	logic [PW-1:0]  ptr_nx;
	logic [NW-1:0]  fill_nx;
	logic           div_start;
	logic [DW-1:0]  div_num;
	logic [15:0]    div_den;
	div_status_t    div_st;
	logic [DW-1:0]  div_quo;
	logic           out_load;
	logic [61:0]    sqr;
	logic [31:0]    y;
	logic [SW-1:0]  p;
	logic signed [LW-1:0]  lval;
	logic signed [PRW-1:0] pmag, rnd, db, lvl, flr, lvl_c;

	swlm_div #(.DW(DW), .VW(16)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.status   (div_st),
		.quotient (div_quo)
	);

	always_comb begin
		blen = (sub_block_samples == 16'd0) ? 16'd1 : sub_block_samples;
		if (window_blocks == 7'd0) begin
			ring_n = NW'(1);
		end else if (32'(window_blocks) > MAXB) begin
			ring_n = NW'(MAXB);
		end else begin
			ring_n = NW'(window_blocks);
		end
		old_e   = rdv_q ? rd_q : '0;
		win_new = ((win_q >= WEW'(old_e)) ? (win_q - WEW'(old_e)) : '0) + WEW'(q_q);
		ptr_nx  = (32'(ptr_q) + 1 >= 32'(ring_n)) ? '0 : ptr_q + PW'(1);
		fill_nx = (fill_q < ring_n) ? fill_q + NW'(1) : fill_q;
		if (state_q == ST_ACCUM) begin
			div_num = DW'(psum_q);
			div_den = pcnt_q;
		end else if (close_q) begin
			div_num = DW'(win_new);
			div_den = (fill_nx == '0) ? 16'd1 : 16'(fill_nx);
		end else begin
			div_num = DW'(win_q) + DW'(q_q);
			div_den = ((fill_q == '0) ? 16'd1 : 16'(fill_q)) + 16'd1;
		end
		sqr = 62'(x_q) * 62'(x_q);
		y   = sqr[61:30];
		p    = SW'(DW - 1) - sc_q;
		lval = LW'($signed({1'b0, p, frac_q})) - LW'(2 * (SB - 1) * 65536);
		pmag = prod_q[PRW-1] ? -prod_q : prod_q;
		rnd  = (pmag + (PRW'(1) <<< 23)) >>> 24;
		db   = prod_q[PRW-1] ? -rnd : rnd;
		lvl  = db + PRW'(calibration_offset);
		flr  = PRW'(silence_floor);
		if (zero_q || lvl < flr) begin
			lvl_c = flr;
		end else if (lvl > PRW'(32767)) begin
			lvl_c = PRW'(32767);
		end else if (lvl < -PRW'(32768)) begin
			lvl_c = -PRW'(32768);
		end else begin
			lvl_c = lvl;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (!empty) state_d = ST_ACCUM;
			ST_ACCUM: state_d = ST_DIV1;
			ST_DIV1:  if (div_st.done) state_d = ST_CLOSE;
			ST_CLOSE: state_d = ST_DIV2;
			ST_DIV2: begin
				if (div_st.done) begin
					state_d = (div_quo == '0) ? ST_FIN : ST_NORM;
				end
			end
			ST_NORM:  if (m_q[DW-1]) state_d = ST_LOG;
			ST_LOG:   if (it_q == 4'd15) state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == ST_IDLE) && !empty;
		div_start = (state_q == ST_ACCUM) || (state_q == ST_CLOSE);
		out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			psum_q      <= '0;
			pcnt_q      <= '0;
			vld_q       <= '0;
			win_q       <= '0;
			ptr_q       <= '0;
			fill_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (clear) begin
			state_q  <= ST_IDLE;
			psum_q   <= '0;
			pcnt_q   <= '0;
			vld_q    <= '0;
			win_q    <= '0;
			ptr_q    <= '0;
			fill_q   <= '0;
			primed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				psum_q <= psum_q + PSW'(rdata);
				pcnt_q <= pcnt_q + 16'd1;
			end
			if (state_q == ST_CLOSE && close_q) begin
				win_q        <= win_new;
				vld_q[ptr_q] <= 1'b1;
				ptr_q        <= ptr_nx;
				fill_q       <= fill_nx;
				if (fill_q < ring_n && fill_nx == ring_n) begin
					primed_q <= 1'b1;
				end
				psum_q <= '0;
				pcnt_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q  <= ring_mem[ptr_q];
		rdv_q <= vld_q[ptr_q];
		if (state_q == ST_CLOSE && close_q) begin
			ring_mem[ptr_q] <= q_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACCUM: close_q <= (pcnt_q >= blen);
			ST_DIV1: begin
				if (div_st.done) begin
					q_q <= div_quo[SQW-1:0];
				end
			end
			ST_DIV2: begin
				if (div_st.done) begin
					m_q    <= div_quo;
					zero_q <= (div_quo == '0);
					sc_q   <= '0;
				end
			end
			ST_NORM: begin
				if (m_q[DW-1]) begin
					x_q    <= m_q[DW-1 -: 31];
					frac_q <= '0;
					it_q   <= 4'd0;
				end else if (m_q[DW-1 -: 8] == 8'd0) begin
					m_q  <= {m_q[DW-9:0], 8'd0};
					sc_q <= sc_q + SW'(8);
				end else begin
					m_q  <= {m_q[DW-2:0], 1'b0};
					sc_q <= sc_q + SW'(1);
				end
			end
			ST_LOG: begin
				it_q   <= it_q + 4'd1;
				frac_q <= {frac_q[14:0], y[31]};
				x_q    <= y[31] ? y[31:1] : y[30:0];
			end
			ST_MUL: prod_q <= PRW'(lval) * PRW'($signed({1'b0, DB_PER_LOG2_Q16}));
			default: begin
			end
		endcase
		if (out_load) begin
			level_q    <= lvl_c[15:0];
			primed_o_q <= primed_q;
			filled_o_q <= 7'(fill_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign level_db      = level_q;
	assign window_primed = primed_o_q;
	assign blocks_filled = filled_o_q;

	a_primed_full: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |-> (fill_q == ring_n))
		else $error("primed flag set while the ring is not full");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!clear |=> (fill_q <= ring_n))
		else $error("filled block count exceeds the ring size");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 || state_q == ST_DIV2) |-> (div_st.busy || div_st.done))
		else $error("waiting on a divider that is not running");

endmodule

>>> rtl/sliding_window_leq_meter_top.sv
// Short-term equivalent level meter: one Q8.8 dBFS level per sample item.
// The back part handles one item at a time; a finished level waits in its last state until the
// output register is free. Most of its work is the shared one-bit-per-cycle divider, which runs
// twice per item (sub-block mean, then window mean). When the window mean is nonzero, a
// normalizing shift and the sixteen squaring steps of the log2 unit follow. A two entry queue
// after the squaring front part keeps accepting items while the back part works, until both
// entries are full. Configuration writes to the block size or ring size restart the
// measurement; the port is always ready.
// Depends on swlm_pkg, swlm_front, swlm_fifo, swlm_div and swlm_back.
module sliding_window_leq_meter_top #(
	parameter int SAMPLE_BITS = swlm_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_BLOCKS  = swlm_pkg::MAX_BLOCKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [15:0]     level_db,
	output logic                   window_primed,
	output logic [6:0]             blocks_filled
);
	import swlm_pkg::*;

	logic [15:0]        sub_block_q;
	logic [6:0]         window_q;
	logic signed [15:0] cal_q;
	logic signed [15:0] floor_q;
	logic               cfg_we;
	logic               clear;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	logic [2*SAMPLE_BITS-2:0] push_data;
	logic [2*SAMPLE_BITS-2:0] rdata;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign clear     = cfg_we && (cfg_index == CFG_SUB_BLOCK || cfg_index == CFG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_block_q <= SUB_BLOCK_RST;
			window_q    <= WINDOW_RST;
			cal_q       <= CAL_RST;
			floor_q     <= FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SUB_BLOCK: sub_block_q <= cfg_data;
				CFG_WINDOW:    window_q    <= cfg_data[6:0];
				CFG_CAL:       cal_q       <= cfg_data;
				CFG_FLOOR:     floor_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	swlm_front #(.SB(SAMPLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	swlm_fifo #(.W(2 * SAMPLE_BITS - 1)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	swlm_back #(.SB(SAMPLE_BITS), .MAXB(MAX_BLOCKS)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.clear              (clear),
		.sub_block_samples  (sub_block_q),
		.window_blocks      (window_q),
		.calibration_offset (cal_q),
		.silence_floor      (floor_q),
		.empty              (empty),
		.rdata              (rdata),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level_db           (level_db),
		.window_primed      (window_primed),
		.blocks_filled      (blocks_filled)
	);

endmodule
